/* hw/rtl/chnbp_pkg.sv */
// chnbp_pkg: types, constants and helpers shared by the next-byte predictor.
// No dependencies.
`default_nettype none

package chnbp_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int MAX_ORDER   = 8;
	localparam int ORDER_W     = 4;
	localparam int KEY_W       = 64;
	localparam int CNT_W       = 32;

	localparam logic [KEY_W-1:0]   HASH_MULT   = 64'd1099511628211;
	localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(MAX_ORDER);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} item_t;

	typedef struct packed {
		logic             context_ready;
		logic             hit;
		logic [7:0]       predicted_byte;
		logic             correct;
		logic [CNT_W-1:0] total_count;
		logic [CNT_W-1:0] covered_count;
		logic [CNT_W-1:0] correct_count;
	} result_t;

	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
		logic [7:0]       follower;
	} entry_t;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic hash;
		logic read;
		logic compare;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic ctx_ready;
		logic probe_done;
		logic out_free;
	} dp_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/chnbp_dp.sv */
// chnbp_dp: datapath of the predictor: history, hash, probe table, counters
// and the result register. Depends on chnbp_pkg.
`default_nettype none

module chnbp_dp import chnbp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_stat_t                stat,
	input  wire item_t              item,
	input  wire logic               cfg_we,
	input  wire logic [ORDER_W-1:0] cfg_data,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output result_t                 result
);

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;

	logic [ORDER_W-1:0] order_q;
	logic [KEY_W-1:0]   hist_q;
	logic [ORDER_W-1:0] seen_q;
	logic [CNT_W-1:0]   att_q, hits_q, rights_q;
	logic [7:0]         byte_q;
	logic [KEY_W-1:0]   key_q;
	logic [IDX_W-1:0]   slot_q;
	logic [IDX_W-1:0]   probes_q;
	logic [IDX_W-1:0]   clr_addr_q;
	logic               ready_q, hit_r_q, good_q;
	logic [7:0]         pred_q;
	logic               result_valid_q;
	result_t            result_q;

	logic [ORDER_W-1:0] ord_eff;
	logic [KEY_W-1:0]   key_d;
	logic [IDX_W-1:0]   prod;
	logic               match, last;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	entry_t             wdata;
	logic [CNT_W-1:0]   att_d, hits_d, rights_d;

	always_comb begin
		if (order_q == '0)
			ord_eff = ORDER_W'(1);
		else if (order_q > ORDER_W'(MAX_ORDER))
			ord_eff = ORDER_W'(MAX_ORDER);
		else
			ord_eff = order_q;
		for (int i = 0; i < KEY_W / 8; i++) begin
			key_d[8*i +: 8] = (ORDER_W'(i) < ord_eff) ? hist_q[8*i +: 8] : 8'h00;
		end
		prod = key_d[IDX_W-1:0] * HASH_MULT[IDX_W-1:0];
	end

	assign match = rd_q.used && (rd_q.key == key_q);
	assign last  = (probes_q == '1);

	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = '0;
		if (cmd.clear_step) begin
			we    = 1'b1;
			waddr = clr_addr_q;
		end else if (cmd.compare && (!rd_q.used || match)) begin
			we    = 1'b1;
			wdata = '{used: 1'b1, key: key_q, follower: byte_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (cmd.read)
			rd_q <= mem[slot_q];
	end

	assign att_d    = ready_q ? sat_inc(att_q) : att_q;
	assign hits_d   = hit_r_q ? sat_inc(hits_q) : hits_q;
	assign rights_d = good_q ? sat_inc(rights_q) : rights_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q        <= ORDER_RESET;
			hist_q         <= '0;
			seen_q         <= '0;
			att_q          <= '0;
			hits_q         <= '0;
			rights_q       <= '0;
			clr_addr_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				order_q <= cfg_data;
			if (cmd.clear_step)
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (cmd.load && item.restart) begin
				hist_q   <= '0;
				seen_q   <= '0;
				att_q    <= '0;
				hits_q   <= '0;
				rights_q <= '0;
			end
			if (cmd.finish) begin
				hist_q   <= {hist_q[KEY_W-9:0], byte_q};
				if (seen_q < ORDER_W'(MAX_ORDER))
					seen_q <= seen_q + ORDER_W'(1);
				att_q    <= att_d;
				hits_q   <= hits_d;
				rights_q <= rights_d;
			end
			if (cmd.finish)
				result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			byte_q <= item.data_byte;
		if (cmd.hash) begin
			key_q    <= key_d;
			slot_q   <= prod;
			probes_q <= '0;
			ready_q  <= (seen_q >= ord_eff);
			hit_r_q  <= 1'b0;
			pred_q   <= 8'h00;
			good_q   <= 1'b0;
		end
		if (cmd.compare) begin
			if (match) begin
				hit_r_q <= 1'b1;
				pred_q  <= rd_q.follower;
				good_q  <= (rd_q.follower == byte_q);
			end else if (rd_q.used) begin
				slot_q   <= slot_q + IDX_W'(1);
				probes_q <= probes_q + IDX_W'(1);
			end
		end
		if (cmd.finish) begin
			result_q.context_ready  <= ready_q;
			result_q.hit            <= hit_r_q;
			result_q.predicted_byte <= pred_q;
			result_q.correct        <= good_q;
			result_q.total_count    <= att_d;
			result_q.covered_count  <= hits_d;
			result_q.correct_count  <= rights_d;
		end
	end

	assign stat.clear_last = (clr_addr_q == IDX_W'(TABLE_DEPTH - 1));
	assign stat.ctx_ready  = ready_q;
	assign stat.probe_done = !rd_q.used || match || last;
	assign stat.out_free   = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

/* hw/rtl/chnbp_ctrl.sv */
// chnbp_ctrl: sequencer for table clearing, hashing, probing and result hand-off.
// Depends on chnbp_pkg.
`default_nettype none

module chnbp_ctrl import chnbp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	input  wire logic     item_restart,
	output logic          item_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = pend_q ? ST_HASH : ST_IDLE;
					pend_d  = 1'b0;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					pend_d   = item_restart;
					state_d  = item_restart ? ST_CLEAR : ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.hash = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = stat.ctx_ready ? ST_CMP : ST_FIN;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = stat.probe_done ? ST_FIN : ST_READ;
			end
			ST_FIN: begin
				cmd.finish = stat.out_free;
				if (stat.out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
				pend_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	assign item_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/context_hash_next_byte_predictor.sv */
// context_hash_next_byte_predictor: order-n hashed context next-byte predictor.
// Depends on chnbp_pkg, chnbp_ctrl, chnbp_dp.
//
// channel  direction  handshake                 payload
// item     in         item_valid / item_stall   item_t   (data_byte, restart)
// result   out        result_valid/result_stall result_t (flags, prediction, counts)
// cfg      in         cfg_valid / cfg_ready     cfg_data (order)
//
// An item is accepted and hashed, then probed (a table read and a compare per probe),
// then its result is loaded once the result register is free; linear probing sets the probe count.
// Without a ready context an item skips the compare: accept, hash, read, result load.
// After reset, and on an item with restart set, a clearing pass writes all
// 4096 table entries, one per cycle, while item_stall is high.
// A finished result waits in its register; the next item is taken meanwhile.
`default_nettype none

module context_hash_next_byte_predictor import chnbp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire item_t              item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output result_t                 result,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [ORDER_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	chnbp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_restart (item.restart),
		.item_stall   (item_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	chnbp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted while another is in progress");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.correct || result.hit) &&
			(!result.hit || result.context_ready) &&
			(result.hit || (result.predicted_byte == 8'h00)))
		else $error("inconsistent result flags");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.correct_count <= result.covered_count) &&
			(result.covered_count <= result.total_count))
		else $error("counters out of order");
`endif

endmodule

`default_nettype wire

/* verif/context_hash_next_byte_predictor_test.sv */
// Self-checking testbench for context_hash_next_byte_predictor: directed and random
// byte streams checked against an in-bench model of the hashed context table.
// Depends on chnbp_pkg and the context_hash_next_byte_predictor RTL.
`default_nettype none

module context_hash_next_byte_predictor_test;
	import chnbp_pkg::*;

	localparam int STALL_LIMIT   = 50000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 136;

	class byte_guess_tracker;
		logic [KEY_W-1:0]   ctx_keys [TABLE_DEPTH];
		logic [7:0]         followers [TABLE_DEPTH];
		bit                 slot_taken [TABLE_DEPTH];
		logic [KEY_W-1:0]   recent_bytes;
		int unsigned        seen_count;
		logic [CNT_W-1:0]   attempt_cnt;
		logic [CNT_W-1:0]   hit_cnt;
		logic [CNT_W-1:0]   right_cnt;
		logic [ORDER_W-1:0] order_reg;
		result_t            expected_guesses [$];
		int unsigned        mismatches;

		function new();
			order_reg = ORDER_RESET;
			mismatches = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			foreach (slot_taken[i]) slot_taken[i] = 1'b0;
			recent_bytes = '0;
			seen_count = 0;
			attempt_cnt = '0;
			hit_cnt = '0;
			right_cnt = '0;
		endfunction

		function void set_order(logic [ORDER_W-1:0] v);
			order_reg = v;
		endfunction

		function int unsigned pending();
			return expected_guesses.size();
		endfunction

		function void note_byte(item_t it);
			result_t          r;
			logic [KEY_W-1:0] key;
			logic [KEY_W-1:0] mixed;
			int unsigned      ord;
			int unsigned      slot;
			int unsigned      probes;
			bit               found;
			ord = 32'(order_reg);
			if (ord < 1) ord = 1;
			if (ord > MAX_ORDER) ord = MAX_ORDER;
			if (it.restart) clear_stream();
			r = '0;
			if (seen_count >= ord) begin
				key = (ord >= 8) ? recent_bytes
				                 : recent_bytes & ((64'd1 << (8 * ord)) - 64'd1);
				mixed = key * HASH_MULT;
				slot = 32'(mixed[IDX_W-1:0]);
				probes = 0;
				found = 1'b0;
				while (slot_taken[slot] && probes < TABLE_DEPTH) begin
					if (ctx_keys[slot] == key) begin
						found = 1'b1;
						break;
					end
					slot = (slot + 1) % TABLE_DEPTH;
					probes++;
				end
				r.context_ready = 1'b1;
				if (attempt_cnt != '1) attempt_cnt++;
				if (found) begin
					r.hit = 1'b1;
					r.predicted_byte = followers[slot];
					if (hit_cnt != '1) hit_cnt++;
					if (followers[slot] == it.data_byte) begin
						r.correct = 1'b1;
						if (right_cnt != '1) right_cnt++;
					end
					followers[slot] = it.data_byte;
				end else if (!slot_taken[slot]) begin
					slot_taken[slot] = 1'b1;
					ctx_keys[slot] = key;
					followers[slot] = it.data_byte;
				end
			end
			r.total_count = attempt_cnt;
			r.covered_count = hit_cnt;
			r.correct_count = right_cnt;
			recent_bytes = {recent_bytes[KEY_W-9:0], it.data_byte};
			if (seen_count < MAX_ORDER) seen_count++;
			expected_guesses.push_back(r);
		endfunction

		function void compare_field(string field, logic [CNT_W-1:0] want,
				logic [CNT_W-1:0] got);
			if (got === want) return;
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_guesses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result transaction with nothing expected: %h", $time, got);
				return;
			end
			want = expected_guesses.pop_front();
			compare_field("context_ready", CNT_W'(want.context_ready),
				CNT_W'(got.context_ready));
			compare_field("hit", CNT_W'(want.hit), CNT_W'(got.hit));
			compare_field("predicted_byte", CNT_W'(want.predicted_byte),
				CNT_W'(got.predicted_byte));
			compare_field("correct", CNT_W'(want.correct), CNT_W'(got.correct));
			compare_field("total_count", want.total_count, got.total_count);
			compare_field("covered_count", want.covered_count, got.covered_count);
			compare_field("correct_count", want.correct_count, got.correct_count);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	item_t              item;
	logic               result_valid;
	logic               result_stall;
	result_t            result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [ORDER_W-1:0] cfg_data;

	byte_guess_tracker tracker;
	int unsigned       idle_cycles;
	bit                gaps_off;

	context_hash_next_byte_predictor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) tracker.check_result(result);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		int unsigned run;
		result_stall <= 1'b0;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				result_stall <= 1'b0;
				run = $urandom_range(20, 200);
			end else if (r < 60) begin
				result_stall <= 1'b0;
				run = $urandom_range(1, 4);
			end else if (r < 88) begin
				result_stall <= 1'b1;
				run = $urandom_range(1, 3);
			end else if (r < 97) begin
				result_stall <= 1'b1;
				run = $urandom_range(4, 12);
			end else begin
				result_stall <= 1'b1;
				run = $urandom_range(30, 80);
			end
			repeat (run) @(posedge clk);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (gaps_off) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(logic [7:0] b, logic rs);
		item_t       it;
		int unsigned gap;
		it.data_byte = b;
		it.restart = rs;
		gap = pick_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		tracker.note_byte(it);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_order(logic [ORDER_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_order(v);
		cfg_valid <= 1'b0;
	endtask

	// Mostly repeated phrases over a small alphabet so contexts recur, with noise bursts.
	task automatic run_phase(int unsigned count);
		logic [7:0]  alphabet [4];
		logic [7:0]  phrases [4][10];
		int unsigned plen [4];
		int unsigned sent;
		int unsigned p;
		int unsigned n;
		int unsigned flip;
		foreach (alphabet[i]) alphabet[i] = 8'($urandom);
		for (int i = 0; i < 4; i++) begin
			plen[i] = $urandom_range(2, 10);
			for (int k = 0; k < 10; k++)
				phrases[i][k] = ($urandom_range(0, 3) != 0) ? alphabet[$urandom_range(0, 3)]
				                                            : 8'($urandom);
		end
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 11) == 0) gaps_off = !gaps_off;
			if ($urandom_range(0, 9) < 7) begin
				p = $urandom_range(0, 3);
				flip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, plen[p] - 1) : 99;
				for (int k = 0; k < plen[p]; k++) begin
					send_byte((k == flip) ? 8'($urandom) : phrases[p][k],
						$urandom_range(0, 69) == 0);
					sent++;
				end
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) begin
					send_byte(8'($urandom), $urandom_range(0, 69) == 0);
					sent++;
				end
			end
		end
		gaps_off = 1'b0;
	endtask

	initial begin
		logic [ORDER_W-1:0] extremes [4];
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= ORDER_RESET;
		idle_cycles = 0;
		gaps_off = 1'b0;
		tracker = new();
		extremes[0] = ORDER_W'(MAX_ORDER);
		extremes[1] = ORDER_W'(1);
		extremes[2] = '1;
		extremes[3] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// order from reset: alternating pattern gives misses, then correct hits
		for (int k = 0; k < 12; k++) send_byte(k[0] ? 8'hFF : 8'h00, 1'b0);
		write_order(ORDER_W'(1));
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		write_order('0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		write_order('1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_order((p < 4) ? extremes[p] : ORDER_W'($urandom_range(0, 15)));
			run_phase(PHASE_ITEMS);
		end

		drain();
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/chnbp_pkg.sv
hw/rtl/chnbp_dp.sv
hw/rtl/chnbp_ctrl.sv
hw/rtl/context_hash_next_byte_predictor.sv
verif/context_hash_next_byte_predictor_test.sv
